// ===== rtl/jsu_pkg.sv =====
// Package for the JSON string unescaper: word types, character codes,
// code point limits and the result group passed from decoder to output buffer.
// No dependencies.
package jsu_pkg;

	localparam int MaxResults = 4;
	localparam int CntWidth   = $clog2(MaxResults + 1);

	typedef struct packed {
		logic [7:0] byte_in;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [7:0] byte_out;
		logic       end_of_string;
		logic       rejected;
	} result_t;

	// One decoded input byte worth of results, loaded into the output buffer at once.
	typedef struct packed {
		logic                         load;
		logic [CntWidth-1:0]          cnt;
		result_t [MaxResults-1:0]     items;
	} res_group_t;

	localparam logic [7:0] ChQuote     = 8'h22;
	localparam logic [7:0] ChBackslash = 8'h5c;
	localparam logic [7:0] ChSlash     = 8'h2f;
	localparam logic [7:0] ChB         = 8'h62;
	localparam logic [7:0] ChF         = 8'h66;
	localparam logic [7:0] ChN         = 8'h6e;
	localparam logic [7:0] ChR         = 8'h72;
	localparam logic [7:0] ChT         = 8'h74;
	localparam logic [7:0] ChU         = 8'h75;
	localparam logic [7:0] ChSpace     = 8'h20;

	localparam logic [15:0] HighSurLo = 16'hd800;
	localparam logic [15:0] HighSurHi = 16'hdbff;
	localparam logic [15:0] LowSurLo  = 16'hdc00;
	localparam logic [15:0] LowSurHi  = 16'hdfff;

	localparam logic [20:0] CpMax     = 21'h10ffff;
	localparam logic [20:0] CpSurLo   = 21'h00d800;
	localparam logic [20:0] CpSurHi   = 21'h00dfff;
	localparam logic [20:0] Min2Byte  = 21'h000080;
	localparam logic [20:0] Min3Byte  = 21'h000800;
	localparam logic [20:0] Min4Byte  = 21'h010000;

	localparam logic [1:0] ClassTwo   = 2'd0;
	localparam logic [1:0] ClassThree = 2'd1;
	localparam logic [1:0] ClassFour  = 2'd2;

endpackage

// ===== rtl/jsu_decode.sv =====
// Input register, escape decoder, UTF-8 encoder and validator for the JSON
// string unescaper. Produces one result group per input word.
// Depends on jsu_pkg.
module jsu_decode import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  item_t      item,
	input  logic       take,
	output res_group_t grp
);

	typedef enum logic [2:0] {
		PH_TEXT  = 3'd0,
		PH_ESC   = 3'd1,
		PH_HEX1  = 3'd2,
		PH_LBSL  = 3'd3,
		PH_LU    = 3'd4,
		PH_HEX2  = 3'd5
	} phase_t;

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd16;
		if (c >= 8'h30 && c <= 8'h39) r = 5'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66) r = 5'(c - 8'h61 + 8'd10);
		else if (c >= 8'h41 && c <= 8'h46) r = 5'(c - 8'h41 + 8'd10);
		return r;
	endfunction

	logic        valid_s1;
	item_t       item_s1;
	logic        advance;

	logic        opened_q, opened_d;
	phase_t      phase_q, phase_d;
	logic [2:0]  hex_left_q, hex_left_d;
	logic [15:0] hex_value_q, hex_value_d;
	logic [9:0]  high_half_q, high_half_d;
	logic [1:0]  pend_q, pend_d;
	logic [20:0] partial_q, partial_d;
	logic [1:0]  class_q, class_d;
	logic        failed_q, failed_d;

	assign advance    = valid_s1 && take;
	assign item_ready = !valid_s1 || take;

	always_comb begin
		logic [7:0]  b;
		logic        raw_go;
		logic        code_go;
		logic [20:0] cp;
		logic [4:0]  d;
		logic [15:0] hv_new;
		logic [2:0]  hl_new;
		logic [20:0] part_new;
		logic [20:0] lowest;
		logic [10:0] plane;

		b        = item_s1.byte_in;
		raw_go   = 1'b0;
		code_go  = 1'b0;
		cp       = '0;
		d        = hex_digit(b);
		hv_new   = {hex_value_q[11:0], d[3:0]};
		hl_new   = hex_left_q - 3'd1;
		part_new = {partial_q[14:0], b[5:0]};
		plane    = 11'(high_half_q) + 11'd64;
		unique case (class_q)
			ClassTwo:   lowest = Min2Byte;
			ClassThree: lowest = Min3Byte;
			default:    lowest = Min4Byte;
		endcase

		opened_d    = opened_q;
		phase_d     = phase_q;
		hex_left_d  = hex_left_q;
		hex_value_d = hex_value_q;
		high_half_d = high_half_q;
		pend_d      = pend_q;
		partial_d   = partial_q;
		class_d     = class_q;
		failed_d    = failed_q;

		grp       = '0;
		grp.load  = advance;

		if (!opened_q) begin
			opened_d = 1'b1;
			if (b != ChQuote || item_s1.last) failed_d = 1'b1;
		end else if (item_s1.last) begin
			if (b != ChQuote || phase_q != PH_TEXT || pend_q != 2'd0) failed_d = 1'b1;
		end else if (!failed_q) begin
			unique case (phase_q)
				PH_TEXT: begin
					if (b < ChSpace || b == ChQuote) failed_d = 1'b1;
					else if (b == ChBackslash) phase_d = PH_ESC;
					else raw_go = 1'b1;
				end
				PH_ESC: begin
					phase_d = PH_TEXT;
					unique case (b)
						ChQuote, ChBackslash, ChSlash: begin
							code_go = 1'b1;
							cp      = 21'(b);
						end
						ChB: begin code_go = 1'b1; cp = 21'h08; end
						ChF: begin code_go = 1'b1; cp = 21'h0c; end
						ChN: begin code_go = 1'b1; cp = 21'h0a; end
						ChR: begin code_go = 1'b1; cp = 21'h0d; end
						ChT: begin code_go = 1'b1; cp = 21'h09; end
						ChU: begin
							phase_d     = PH_HEX1;
							hex_left_d  = 3'd4;
							hex_value_d = '0;
						end
						default: failed_d = 1'b1;
					endcase
				end
				PH_HEX1, PH_HEX2: begin
					if (d[4]) begin
						failed_d = 1'b1;
					end else begin
						hex_value_d = hv_new;
						hex_left_d  = hl_new;
						if (hl_new == 3'd0) begin
							if (phase_q == PH_HEX1) begin
								if (hv_new >= HighSurLo && hv_new <= HighSurHi) begin
									high_half_d = hv_new[9:0];
									phase_d     = PH_LBSL;
								end else if (hv_new >= LowSurLo && hv_new <= LowSurHi) begin
									failed_d = 1'b1;
								end else begin
									phase_d = PH_TEXT;
									code_go = 1'b1;
									cp      = 21'(hv_new);
								end
							end else begin
								if (hv_new < LowSurLo || hv_new > LowSurHi) begin
									failed_d = 1'b1;
								end else begin
									phase_d = PH_TEXT;
									code_go = 1'b1;
									cp      = {plane, hv_new[9:0]};
								end
							end
						end
					end
				end
				PH_LBSL: begin
					if (b == ChBackslash) phase_d = PH_LU;
					else failed_d = 1'b1;
				end
				PH_LU: begin
					if (b == ChU) begin
						phase_d     = PH_HEX2;
						hex_left_d  = 3'd4;
						hex_value_d = '0;
					end else begin
						failed_d = 1'b1;
					end
				end
				default: failed_d = 1'b1;
			endcase
		end

		// Raw byte: run it through the UTF-8 validator.
		if (raw_go) begin
			if (pend_q == 2'd0) begin
				priority if (!b[7]) begin
					grp.cnt = CntWidth'(1);
				end else if (b[7:5] == 3'b110) begin
					pend_d = 2'd1; partial_d = 21'(b[4:0]); class_d = ClassTwo;
					grp.cnt = CntWidth'(1);
				end else if (b[7:4] == 4'b1110) begin
					pend_d = 2'd2; partial_d = 21'(b[3:0]); class_d = ClassThree;
					grp.cnt = CntWidth'(1);
				end else if (b[7:3] == 5'b11110) begin
					pend_d = 2'd3; partial_d = 21'(b[2:0]); class_d = ClassFour;
					grp.cnt = CntWidth'(1);
				end else begin
					failed_d = 1'b1;
				end
			end else if (b[7:6] != 2'b10) begin
				failed_d = 1'b1;
			end else begin
				partial_d = part_new;
				pend_d    = pend_q - 2'd1;
				if (pend_q == 2'd1 && (part_new < lowest || part_new > CpMax ||
						(part_new >= CpSurLo && part_new <= CpSurHi))) begin
					failed_d = 1'b1;
				end else begin
					grp.cnt = CntWidth'(1);
				end
			end
			grp.items[0].byte_out = b;
		end

		// Decoded code point: well formed, so it only fails inside an open sequence.
		if (code_go) begin
			if (pend_q != 2'd0) begin
				failed_d = 1'b1;
			end else if (cp < Min2Byte) begin
				grp.cnt = CntWidth'(1);
				grp.items[0].byte_out = cp[7:0];
			end else if (cp < Min3Byte) begin
				grp.cnt = CntWidth'(2);
				grp.items[0].byte_out = {3'b110, cp[10:6]};
				grp.items[1].byte_out = {2'b10, cp[5:0]};
			end else if (cp < Min4Byte) begin
				grp.cnt = CntWidth'(3);
				grp.items[0].byte_out = {4'b1110, cp[15:12]};
				grp.items[1].byte_out = {2'b10, cp[11:6]};
				grp.items[2].byte_out = {2'b10, cp[5:0]};
			end else begin
				grp.cnt = CntWidth'(4);
				grp.items[0].byte_out = {5'b11110, cp[20:18]};
				grp.items[1].byte_out = {2'b10, cp[17:12]};
				grp.items[2].byte_out = {2'b10, cp[11:6]};
				grp.items[3].byte_out = {2'b10, cp[5:0]};
			end
		end

		// Closing word: emit the status and drop back to the idle state.
		if (item_s1.last) begin
			grp.cnt                    = CntWidth'(1);
			grp.items[0].byte_out      = '0;
			grp.items[0].end_of_string = 1'b1;
			grp.items[0].rejected      = failed_d;
			opened_d    = 1'b0;
			phase_d     = PH_TEXT;
			hex_left_d  = '0;
			hex_value_d = '0;
			high_half_d = '0;
			pend_d      = '0;
			partial_d   = '0;
			class_d     = '0;
			failed_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			opened_q    <= 1'b0;
			phase_q     <= PH_TEXT;
			hex_left_q  <= '0;
			hex_value_q <= '0;
			high_half_q <= '0;
			pend_q      <= '0;
			partial_q   <= '0;
			class_q     <= '0;
			failed_q    <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				opened_q    <= opened_d;
				phase_q     <= phase_d;
				hex_left_q  <= hex_left_d;
				hex_value_q <= hex_value_d;
				high_half_q <= high_half_d;
				pend_q      <= pend_d;
				partial_q   <= partial_d;
				class_q     <= class_d;
				failed_q    <= failed_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

endmodule

// ===== rtl/jsu_out_buf.sv =====
// Result register for the JSON string unescaper: holds up to four result
// words from one input word and hands them out one per cycle while
// result_ready is high. Depends on jsu_pkg.
module jsu_out_buf import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  res_group_t grp,
	output logic       take,
	output logic       result_valid,
	input  logic       result_ready,
	output result_t    result
);

	localparam int IdxWidth = $clog2(MaxResults);

	result_t [MaxResults-1:0] items_q;
	logic [CntWidth-1:0]      cnt_q;
	logic [IdxWidth-1:0]      idx_q;

	assign result_valid = cnt_q != '0;
	assign result       = items_q[idx_q];
	// Free when empty or when the last held word leaves this cycle.
	assign take = (cnt_q == '0) || (cnt_q == CntWidth'(1) && result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (grp.load) begin
			cnt_q <= grp.cnt;
			idx_q <= '0;
		end else if (result_valid && result_ready) begin
			cnt_q <= cnt_q - CntWidth'(1);
			idx_q <= idx_q + IdxWidth'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (grp.load) begin
			items_q <= grp.items;
		end
	end

endmodule

// ===== rtl/json_string_unescape.sv =====
// Streaming JSON string unescaper with UTF-8 check: takes the raw bytes of one
// quoted string (last set on the closing quote), and returns the decoded UTF-8
// bytes followed by one end_of_string word whose rejected bit tells whether the
// string was valid; drop all bytes of a rejected string. One input byte is taken
// per cycle unless held; each byte yields zero to four result words, and the
// result register hands them out one per cycle while result_ready is high, so
// a byte with more than one word holds the input until its last word leaves, as
// on the last hex digit of a \u escape, no matter how many bytes the escape took
// before it. Data passes an input and a result register. Depends on jsu_pkg.
module json_string_unescape import jsu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	res_group_t grp;
	logic       take;

	jsu_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.take       (take),
		.grp        (grp)
	);

	jsu_out_buf u_out_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.grp          (grp),
		.take         (take),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
